>>> src/rau_pkg.sv
// Shared types, widths and codes for the rational arithmetic unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_BITS = 16;
    // Widest working value: sum of two products plus sign.
    localparam int MAG_W        = 2 * OPERAND_BITS + 1;
    localparam int CNT_W        = $clog2(MAG_W + 1);
    localparam int PROD_W       = 2 * OPERAND_BITS;
    localparam int RES_NUM_W    = 33;
    localparam int RES_DEN_W    = 32;
    localparam int MODE_W       = 3;

    typedef logic [MODE_W-1:0]              t_mode;
    typedef logic signed [OPERAND_BITS-1:0] t_opnd;
    typedef logic signed [MAG_W-1:0]        t_wide;
    typedef logic [MAG_W-1:0]               t_mag;

    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_SUB = 3'd1;
    localparam t_mode MODE_MUL = 3'd2;
    localparam t_mode MODE_DIV = 3'd3;
    localparam t_mode MODE_EQU = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_START,
        S_GCD_WAIT,
        S_DIV_START,
        S_DIV_WAIT,
        S_STORE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_RESULT
    } t_phase;

    // Handshake between sequencer and an iterative unit.
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic t_mag magnitude(input t_wide v);
        magnitude = v[MAG_W-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

endpackage

>>> src/rau_gcd.sv
// Iterative binary gcd, one subtract-or-shift step per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_gcd
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_ctl i_ctl,
    input  t_mag      i_a,
    input  t_mag      i_b,
    output t_unit_sts o_sts,
    output t_mag      o_gcd
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_mag             r_a, n_a;
    t_mag             r_b, n_b;
    t_mag             r_g, n_g;
    logic [CNT_W-1:0] r_k, n_k;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_g    = r_g;
        n_k    = r_k;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_k    = '0;
        end else if (r_busy) begin
            if (r_a == '0) begin
                n_g    = r_b << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_b == '0) begin
                n_g    = r_a << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = (r_a - r_b) >> 1;
            end else begin
                n_b = (r_b - r_a) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_g <= n_g;
        r_k <= n_k;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_gcd      = r_g;

endmodule

>>> src/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_div
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_ctl i_ctl,
    input  t_mag      i_dividend,
    input  t_mag      i_divisor,
    output t_unit_sts o_sts,
    output t_mag      o_quot
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_mag             r_q, n_q;
    t_mag             r_dvs, n_dvs;
    logic [MAG_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        trial  = {r_rem[MAG_W-1:0], r_q[MAG_W-1]};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_q   = {r_q[MAG_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q   = {r_q[MAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

>>> src/rational_arithmetic_unit.sv
// Top level: sequencer, shared multiplier and output register of the
// rational arithmetic unit. Depends on rau_pkg, rau_gcd and rau_div.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_mode, i_left_num, i_left_den,
//          |           |                             | i_right_num, i_right_den
//  out     | output    | o_out_valid / i_out_stall   | o_result_num, o_result_den,
//          |           |                             | o_is_equal, o_zero_den_fixed
//
//  Each transfer in runs three reductions (left, right, result): each
//  runs the binary gcd and then two divisions on the shared divider, and
//  the products pass through the multiplier states S_MUL0 to S_MUL3.
//  Equality and unused modes skip the products and the result reduction.
//  Reset (i_rst_n low, synchronous) idles the sequencer and empties the
//  output register. o_in_stall is high while an item is in work; a held
//  result waits in the output register and does not block the next input.

module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [MODE_W-1:0]           i_mode,
    input  logic signed [OPERAND_BITS-1:0] i_left_num,
    input  logic signed [OPERAND_BITS-1:0] i_left_den,
    input  logic signed [OPERAND_BITS-1:0] i_right_num,
    input  logic signed [OPERAND_BITS-1:0] i_right_den,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [RES_NUM_W-1:0] o_result_num,
    output logic signed [RES_DEN_W-1:0] o_result_den,
    output logic                        o_is_equal,
    output logic                        o_zero_den_fixed
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    // Item registers
    t_mode  r_mode, n_mode;
    t_opnd  r_rn_in, n_rn_in;        // right operand, held until its turn
    t_opnd  r_rd_in, n_rd_in;
    t_opnd  r_a, n_a;                // canonical left
    t_opnd  r_b, n_b;
    t_opnd  r_c, n_c;                // canonical right
    t_opnd  r_d, n_d;
    t_wide  r_wn, n_wn;              // fraction being reduced
    t_wide  r_wd, n_wd;
    t_mag   r_g, n_g;
    logic   r_div_sel, n_div_sel;    // 0: numerator, 1: denominator
    logic   r_fixed, n_fixed;
    logic   r_eq, n_eq;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PROD_W-1:0] r_p0, n_p0;

    // Output register
    logic   r_ovalid, n_ovalid;
    t_wide  r_onum, n_onum;
    t_wide  r_oden, n_oden;
    logic   r_oeq, n_oeq;
    logic   r_ofix, n_ofix;

    // Shared units
    t_unit_ctl gcd_ctl, div_ctl;
    t_unit_sts gcd_sts, div_sts;
    t_mag      gcd_val, div_quot, div_num;
    t_opnd     mul_x, mul_y;
    logic      in_xfer, out_free;
    logic      neg_sel;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gcd_ctl),
        .i_a     (magnitude(r_wn)),
        .i_b     (magnitude(r_wd)),
        .o_sts   (gcd_sts),
        .o_gcd   (gcd_val)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_num),
        .i_divisor  (r_g),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    assign div_num  = r_div_sel ? magnitude(r_wd) : magnitude(r_wn);
    assign neg_sel  = r_div_sel ? r_wd[MAG_W-1] : r_wn[MAG_W-1];
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    // Multiplier operand select: products a*d / a*c first, then c*b (add and
    // subtract only), then the denominator b*d (or b*c when dividing).
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            S_MUL0: begin
                mul_x = r_a;
                mul_y = (r_mode == MODE_MUL) ? r_c : r_d;
            end
            S_MUL1: begin
                if (r_mode == MODE_ADD || r_mode == MODE_SUB) begin
                    mul_x = r_c;
                    mul_y = r_b;
                end
            end
            S_MUL2: begin
                mul_x = r_b;
                mul_y = (r_mode == MODE_DIV) ? r_c : r_d;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_rn_in   = r_rn_in;
        n_rd_in   = r_rd_in;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_wn      = r_wn;
        n_wd      = r_wd;
        n_g       = r_g;
        n_div_sel = r_div_sel;
        n_fixed   = r_fixed;
        n_eq      = r_eq;
        n_prod    = mul_x * mul_y;
        n_p0      = r_p0;
        n_ovalid  = r_ovalid && i_out_stall;
        n_onum    = r_onum;
        n_oden    = r_oden;
        n_oeq     = r_oeq;
        n_ofix    = r_ofix;
        gcd_ctl.start = 1'b0;
        div_ctl.start = 1'b0;
        o_in_stall = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode  = i_mode;
                    n_rn_in = i_right_num;
                    n_rd_in = i_right_den;
                    n_wn    = t_wide'(i_left_num);
                    n_wd    = (i_left_den == '0) ? t_wide'(1) : t_wide'(i_left_den);
                    n_fixed = (i_left_den == '0);
                    n_eq    = 1'b0;
                    n_phase = PH_LEFT;
                    n_state = S_GCD_START;
                end
            end
            S_GCD_START: begin
                gcd_ctl.start = 1'b1;
                n_state       = S_GCD_WAIT;
            end
            S_GCD_WAIT: begin
                if (gcd_sts.done) begin
                    n_g       = gcd_val;
                    n_div_sel = 1'b0;
                    n_state   = S_DIV_START;
                end
            end
            S_DIV_START: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_sts.done) begin
                    if (!r_div_sel) begin
                        n_wn      = neg_sel ? -t_wide'(div_quot) : t_wide'(div_quot);
                        n_div_sel = 1'b1;
                        n_state   = S_DIV_START;
                    end else begin
                        n_wd    = neg_sel ? -t_wide'(div_quot) : t_wide'(div_quot);
                        n_state = S_STORE;
                    end
                end
            end
            S_STORE: begin
                case (r_phase)
                    PH_LEFT: begin
                        n_a     = t_opnd'(r_wn);
                        n_b     = t_opnd'(r_wd);
                        n_wn    = t_wide'(r_rn_in);
                        n_wd    = (r_rd_in == '0) ? t_wide'(1) : t_wide'(r_rd_in);
                        n_fixed = r_fixed || (r_rd_in == '0);
                        n_phase = PH_RIGHT;
                        n_state = S_GCD_START;
                    end
                    PH_RIGHT: begin
                        n_c = t_opnd'(r_wn);
                        n_d = t_opnd'(r_wd);
                        if (r_mode == MODE_EQU) begin
                            n_eq    = (r_a == t_opnd'(r_wn)) && (r_b == t_opnd'(r_wd));
                            n_wn    = '0;
                            n_wd    = '0;
                            n_state = S_DONE;
                        end else if (r_mode > MODE_EQU) begin
                            n_wn    = '0;
                            n_wd    = '0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MUL0;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MUL0: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_p0    = r_prod;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                if (r_mode == MODE_SUB) begin
                    n_wn = t_wide'(r_p0) - t_wide'(r_prod);
                end else begin
                    n_wn = t_wide'(r_p0) + t_wide'(r_prod);
                end
                n_state = S_MUL3;
            end
            S_MUL3: begin
                // Dividing by a zero fraction gives a zero denominator; it becomes one, flagged.
                if (r_prod == '0) begin
                    n_wd    = t_wide'(1);
                    n_fixed = 1'b1;
                end else begin
                    n_wd = t_wide'(r_prod);
                end
                n_phase = PH_RESULT;
                n_state = S_GCD_START;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_wn;
                    n_oden   = r_wd;
                    n_oeq    = r_eq;
                    n_ofix   = r_fixed;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_LEFT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
        r_mode    <= n_mode;
        r_rn_in   <= n_rn_in;
        r_rd_in   <= n_rd_in;
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_d       <= n_d;
        r_wn      <= n_wn;
        r_wd      <= n_wd;
        r_g       <= n_g;
        r_div_sel <= n_div_sel;
        r_fixed   <= n_fixed;
        r_eq      <= n_eq;
        r_prod    <= n_prod;
        r_p0      <= n_p0;
        r_onum    <= n_onum;
        r_oden    <= n_oden;
        r_oeq     <= n_oeq;
        r_ofix    <= n_ofix;
    end

    assign o_out_valid      = r_ovalid;
    assign o_result_num     = RES_NUM_W'(r_onum);
    assign o_result_den     = RES_DEN_W'(r_oden);
    assign o_is_equal       = r_oeq;
    assign o_zero_den_fixed = r_ofix;

    // The sequencer leaves idle after every input transfer.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("input transfer did not start the sequencer");

    // gcd and divider never run together.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(gcd_sts.busy && div_sts.busy))
        else $error("gcd and divider busy together");

    // A zero denominator only appears with a zero numerator (equality and unused modes).
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_den == '0 |-> o_result_num == '0)
        else $error("zero denominator on an arithmetic result");

    // A true equality result carries no fraction.
    a_eq_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_equal |-> o_result_num == '0 && o_result_den == '0)
        else $error("equality result with non-zero fraction");

endmodule

>>> bench/rational_arithmetic_unit_tb.sv
// Self-checking bench for rational_arithmetic_unit: directed and random fractions,
// predicted in-bench and compared per result. Depends on rau_pkg and the RTL.
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    // one expected result
    typedef struct {
        logic signed [RES_NUM_W-1:0] num;
        logic signed [RES_DEN_W-1:0] den;
        logic                        eq;
        logic                        fixed;
    } t_frac_res;

    localparam int WATCHDOG = 20000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [MODE_W-1:0]             i_mode;
    logic signed [OPERAND_BITS-1:0] i_left_num, i_left_den, i_right_num, i_right_den;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [RES_NUM_W-1:0]   o_result_num;
    logic signed [RES_DEN_W-1:0]   o_result_den;
    logic                          o_is_equal;
    logic                          o_zero_den_fixed;

    t_frac_res pending_q[$];
    int        mismatches;
    int        idle_cycles;
    bit        timed_out;

    rational_arithmetic_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // --- predictor -------------------------------------------------------
    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned gcd64(input longint unsigned a,
                                              input longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // zero denominator becomes one (flagged), then reduce by gcd
    function automatic void reduce_frac(inout longint n, inout longint d, inout bit fixed);
        longint unsigned g;
        if (d == 0) begin
            d = 1;
            fixed = 1'b1;
        end
        g = gcd64(abs64(n), abs64(d));
        if (g != 0) begin
            n = n / longint'(g);
            d = d / longint'(g);
        end
    endfunction

    function automatic t_frac_res predict_fraction(input logic [MODE_W-1:0] m,
            input t_opnd ln, input t_opnd ld, input t_opnd rn, input t_opnd rd);
        longint    a, b, c, d, pn, pd;
        bit        fixed, arith;
        t_frac_res r;
        a = ln; b = ld; c = rn; d = rd;
        pn = 0; pd = 0; fixed = 0; arith = 1;
        r.eq = 1'b0;
        reduce_frac(a, b, fixed);
        reduce_frac(c, d, fixed);
        case (m)
            MODE_ADD: begin pn = a * d + c * b; pd = b * d; end
            MODE_SUB: begin pn = a * d - c * b; pd = b * d; end
            MODE_MUL: begin pn = a * c; pd = b * d; end
            MODE_DIV: begin pn = a * d; pd = b * c; end
            MODE_EQU: begin r.eq = (a == c) && (b == d); arith = 0; end
            default:  arith = 0;
        endcase
        if (arith) reduce_frac(pn, pd, fixed);
        r.num   = pn[RES_NUM_W-1:0];
        r.den   = pd[RES_DEN_W-1:0];
        r.fixed = fixed;
        return r;
    endfunction

    // mostly short gaps, occasionally long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // --- stimulus --------------------------------------------------------
    task automatic send_fraction(input logic [MODE_W-1:0] m, input t_opnd ln,
            input t_opnd ld, input t_opnd rn, input t_opnd rd);
        int gap;
        i_mode      <= m;
        i_left_num  <= ln;
        i_left_den  <= ld;
        i_right_num <= rn;
        i_right_den <= rd;
        i_in_valid  <= 1'b1;
        pending_q.push_back(predict_fraction(m, ln, ld, rn, rd));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = gap_len();
        @(negedge i_clk);
        // with no gap, valid stays high and the next item follows directly
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_opnd rand_opnd();
        case ($urandom_range(0, 5))
            0:       return t_opnd'($urandom_range(0, 8)) - 16'sd4;
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2:       return t_opnd'($urandom_range(0, 60)) - 16'sd30;
            default: return t_opnd'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        logic [MODE_W-1:0] m;
        for (int k = 0; k < 8; k++) begin
            m = MODE_W'(k);
            send_fraction(m, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
        end
        send_fraction(MODE_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_fraction(MODE_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
        send_fraction(MODE_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh7fff);
        send_fraction(MODE_SUB, 16'sh8000, 16'sd1, 16'sh7fff, 16'sd1);
        send_fraction(MODE_ADD, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    endtask

    task automatic test_special_cases();
        send_fraction(MODE_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2);      // zero left den
        send_fraction(MODE_MUL, 16'sd5, 16'sd7, 16'sd2, 16'sd0);      // zero right den
        send_fraction(MODE_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);      // divide by zero
        send_fraction(MODE_DIV, 16'sd3, 16'sd0, 16'sd0, 16'sd0);
        send_fraction(MODE_ADD, 16'sd0, -16'sd6, 16'sd0, 16'sd4);     // zero numerators
        send_fraction(MODE_SUB, 16'sd1, -16'sd2, 16'sd1, -16'sd2);
        send_fraction(MODE_EQU, 16'sd2, 16'sd4, 16'sd1, 16'sd2);      // equal after reduction
        send_fraction(MODE_EQU, 16'sd1, -16'sd2, -16'sd1, 16'sd2);    // sign kept on den
        send_fraction(MODE_EQU, 16'sd5, 16'sd0, 16'sd5, 16'sd1);
        send_fraction(3'd6, 16'sd1, 16'sd0, 16'sd2, 16'sd3);          // unused mode
    endtask

    task automatic test_random(input int count);
        t_opnd ln, ld, rn, rd;
        logic [MODE_W-1:0] m;
        for (int k = 0; k < count; k++) begin
            m  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            ln = rand_opnd(); ld = rand_opnd();
            if ($urandom_range(0, 3) == 0) begin
                rn = ln; rd = ld;              // equal fractions
            end else begin
                rn = rand_opnd(); rd = rand_opnd();
            end
            send_fraction(m, ln, ld, rn, rd);
        end
    endtask

    // --- output side -----------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            int hold;
            @(negedge i_clk);
            hold = gap_len();
            if ($urandom_range(0, 2) == 0 && hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_frac_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                exp_r = pending_q.pop_front();
                if (o_result_num !== exp_r.num || o_result_den !== exp_r.den ||
                    o_is_equal !== exp_r.eq || o_zero_den_fixed !== exp_r.fixed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d eq=%0b fx=%0b got %0d/%0d eq=%0b fx=%0b",
                                 exp_r.num, exp_r.den, exp_r.eq, exp_r.fixed,
                                 o_result_num, o_result_den, o_is_equal, o_zero_den_fixed);
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = '0;
        i_left_num  = '0;
        i_left_den  = '0;
        i_right_num = '0;
        i_right_den = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_special_cases();
        test_random(1950);
        i_in_valid <= 1'b0;

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
src/rau_pkg.sv
src/rau_gcd.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
